FILE: hw/rtl/llcpwm_pkg.sv
// ----------------------------------------------------------------------------
// llcpwm_pkg
// Shared types, constants and pattern table of the LLC PWM pattern and
// period updater.
// ----------------------------------------------------------------------------
package llcpwm_pkg;

    // field widths
    localparam int PER_W   = 16;
    localparam int DEAD_W  = 12;
    localparam int FREQ_W  = 20;
    localparam int SEL_W   = 8;
    localparam int PAT_W   = 4;
    localparam int MASK_W  = 6;
    localparam int NUM_W   = 32;
    localparam int CNT_W   = 5;
    localparam int CIDX_W  = 8;
    localparam int CDATA_W = 16;

    // structure of the pattern table
    localparam int CHANNELS = 3;
    localparam int NUM_CMP  = 2 * CHANNELS;
    localparam int PATTERNS = 8;

    // one quotient bit per divider step
    localparam int DIV_STEPS = NUM_W;

    localparam logic [PER_W-1:0] NOMINAL_HZ = 16'd50000;
    localparam logic [PER_W-1:0] SAT_PERIOD = 16'hFFFF;

    // reset values
    localparam logic [PER_W-1:0]  RST_BASE_PERIOD = 16'd1000;
    localparam logic [DEAD_W-1:0] RST_DEAD_COUNT  = 12'd50;
    localparam logic [PER_W-1:0]  RST_MIN_PERIOD  = 16'd500;
    localparam logic [PER_W-1:0]  RST_MAX_PERIOD  = 16'd2000;
    localparam logic [PER_W-1:0]  RST_PERIOD      = 16'd1000;
    localparam logic [PAT_W-1:0]  RST_PATTERN     = 4'd1;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_BASE_PERIOD = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_DEAD_COUNT  = 8'd1;
    localparam logic [CIDX_W-1:0] CFG_MIN_PERIOD  = 8'd2;
    localparam logic [CIDX_W-1:0] CFG_MAX_PERIOD  = 8'd3;

    // compare codes of the pattern table
    localparam logic [1:0] CMP_PER    = 2'd0;
    localparam logic [1:0] CMP_HMINUS = 2'd1;
    localparam logic [1:0] CMP_HPLUS  = 2'd2;

    typedef logic [NUM_CMP-1:0][1:0] t_codes;

    typedef struct packed {
        logic              start_request;
        logic [SEL_W-1:0]  pattern_select;
        logic [FREQ_W-1:0] freq_hz;
    } t_in;

    typedef struct packed {
        logic              trip_forced;
        logic [PER_W-1:0]  period_out;
        logic [MASK_W-1:0] action_high_mask;
        logic [PER_W-1:0]  cmp_1a;
        logic [PER_W-1:0]  cmp_1b;
        logic [PER_W-1:0]  cmp_2a;
        logic [PER_W-1:0]  cmp_2b;
        logic [PER_W-1:0]  cmp_3a;
        logic [PER_W-1:0]  cmp_3b;
        logic              compares_updated;
    } t_out;

    typedef struct packed {
        logic [PER_W-1:0]  base_period;
        logic [DEAD_W-1:0] dead_count;
        logic [PER_W-1:0]  min_period;
        logic [PER_W-1:0]  max_period;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic mul_load;
        logic div_step;
        logic commit;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic start_low;
        logic div_last;
        logic out_free;
    } t_sts;

    // action polarity mask per pattern, bits 1A,1B,2A,2B,3A,3B
    function automatic logic [MASK_W-1:0] rom_mask(input logic [2:0] idx);
        logic [MASK_W-1:0] m;
        unique case (idx)
            3'd0: m = 6'h19;
            3'd1: m = 6'h26;
            3'd2: m = 6'h19;
            3'd3: m = 6'h29;
            3'd4: m = 6'h25;
            3'd5: m = 6'h2D;
            3'd6: m = 6'h1E;
            3'd7: m = 6'h2D;
        endcase
        return m;
    endfunction

    // compare codes per pattern, element 0 is 1A
    function automatic t_codes rom_codes(input logic [2:0] idx);
        t_codes c;
        unique case (idx)
            3'd0: c = {CMP_PER, CMP_HMINUS, CMP_PER, CMP_HPLUS, CMP_PER, CMP_HMINUS};
            3'd1: c = {CMP_HMINUS, CMP_PER, CMP_HPLUS, CMP_PER, CMP_HMINUS, CMP_PER};
            3'd2: c = {CMP_HPLUS, CMP_HMINUS, CMP_HMINUS, CMP_HPLUS, CMP_HPLUS, CMP_HMINUS};
            3'd3: c = {CMP_HMINUS, CMP_HPLUS, CMP_HMINUS, CMP_HPLUS, CMP_HPLUS, CMP_HMINUS};
            3'd4: c = {CMP_HMINUS, CMP_HPLUS, CMP_HPLUS, CMP_HMINUS, CMP_HPLUS, CMP_HMINUS};
            3'd5: c = {CMP_HMINUS, CMP_PER, CMP_PER, CMP_PER, CMP_HPLUS, CMP_PER};
            3'd6: c = {CMP_PER, CMP_HMINUS, CMP_PER, CMP_PER, CMP_PER, CMP_HPLUS};
            3'd7: c = {CMP_HMINUS, CMP_HPLUS, CMP_PER, CMP_PER, CMP_HPLUS, CMP_HMINUS};
        endcase
        return c;
    endfunction

    // full period, or half period plus or minus dead band, clamped to 0..period
    function automatic logic [PER_W-1:0] calc_compare(
        input logic [1:0]        code,
        input logic [PER_W-1:0]  period,
        input logic [DEAD_W-1:0] dead
    );
        logic [PER_W-1:0] half;
        logic [PER_W-1:0] dead_x;
        logic [PER_W:0]   sum;
        logic [PER_W-1:0] v;
        half   = {1'b0, period[PER_W-1:1]};
        dead_x = {{(PER_W-DEAD_W){1'b0}}, dead};
        sum    = {1'b0, half} + {1'b0, dead_x};
        case (code)
            CMP_HMINUS: v = (dead_x > half) ? '0 : half - dead_x;
            CMP_HPLUS:  v = (sum > {1'b0, period}) ? period : sum[PER_W-1:0];
            default:    v = period;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/llcpwm_ctrl.sv
// ----------------------------------------------------------------------------
// llcpwm_ctrl
// Sequencer of the updater: takes one request, runs the multiply and, for
// start high, the serial divide, commits the new state, outputs the result.
// ----------------------------------------------------------------------------
module llcpwm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  llcpwm_pkg::t_sts  i_sts,
    output llcpwm_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_state        = i_sts.start_low ? ST_FIN : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // requests are taken only between items
    assign o_in_stall = (r_state != ST_IDLE);

endmodule

FILE: hw/rtl/llcpwm_dp.sv
// ----------------------------------------------------------------------------
// llcpwm_dp
// Datapath: request latch, period multiply, restoring divider, clamp,
// pattern table lookup, control state and output register.
// ----------------------------------------------------------------------------
module llcpwm_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  llcpwm_pkg::t_cfg  i_cfg,
    input  llcpwm_pkg::t_in   i_in_data,
    output llcpwm_pkg::t_out  o_out_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  llcpwm_pkg::t_cmd  i_cmd,
    output llcpwm_pkg::t_sts  o_sts
);

    // request latch
    llcpwm_pkg::t_in r_in;

    // divider
    logic [llcpwm_pkg::NUM_W-1:0]  r_num;
    logic [llcpwm_pkg::FREQ_W-1:0] r_rem;
    logic [llcpwm_pkg::CNT_W-1:0]  r_cnt;
    logic [llcpwm_pkg::FREQ_W:0]   rem_sh;
    logic                          q_bit;

    // control state
    logic                          r_armed, n_armed;
    logic [llcpwm_pkg::PAT_W-1:0]  r_active, n_active;
    logic [llcpwm_pkg::PER_W-1:0]  r_period, n_period;
    logic                          r_pat_pend, n_pat_pend;
    logic                          r_per_pend, n_per_pend;
    logic                          r_trip, n_trip;
    logic [llcpwm_pkg::MASK_W-1:0] r_action, n_action;
    logic [llcpwm_pkg::PER_W-1:0]  r_cmp [llcpwm_pkg::NUM_CMP];
    logic [llcpwm_pkg::PER_W-1:0]  n_cmp [llcpwm_pkg::NUM_CMP];
    logic                          r_updated, n_updated;

    // output register
    logic                          r_out_valid;
    llcpwm_pkg::t_out              r_out;

    // period and pattern terms
    logic                          sat;
    logic [llcpwm_pkg::PER_W-1:0]  sat_per;
    logic [llcpwm_pkg::PER_W-1:0]  np;
    logic                          sel_valid;
    logic [2:0]                    rom_idx;
    llcpwm_pkg::t_codes            codes;

    // request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_data;
        end
    end

    // one restoring divide step: shift remainder, subtract when it fits
    assign rem_sh = {r_rem, r_num[llcpwm_pkg::NUM_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_in.freq_hz});

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_num <= llcpwm_pkg::NUM_W'(i_cfg.base_period)
                     * llcpwm_pkg::NUM_W'(llcpwm_pkg::NOMINAL_HZ);
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[llcpwm_pkg::NUM_W-2:0], q_bit};
            r_rem <= q_bit ? llcpwm_pkg::FREQ_W'(rem_sh - {1'b0, r_in.freq_hz})
                           : rem_sh[llcpwm_pkg::FREQ_W-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // saturate then clamp, min limit first
    assign sat     = (r_num[llcpwm_pkg::NUM_W-1:llcpwm_pkg::PER_W] != '0)
                     || (r_in.freq_hz == '0);
    assign sat_per = sat ? llcpwm_pkg::SAT_PERIOD : r_num[llcpwm_pkg::PER_W-1:0];

    always_comb begin
        if (sat_per < i_cfg.min_period) begin
            np = i_cfg.min_period;
        end else if (sat_per > i_cfg.max_period) begin
            np = i_cfg.max_period;
        end else begin
            np = sat_per;
        end
    end

    // pattern table lookup
    assign sel_valid = (r_in.pattern_select >= llcpwm_pkg::SEL_W'(1))
                       && (r_in.pattern_select <= llcpwm_pkg::SEL_W'(llcpwm_pkg::PATTERNS));
    assign rom_idx   = 3'(r_in.pattern_select - llcpwm_pkg::SEL_W'(1));
    assign codes     = llcpwm_pkg::rom_codes(rom_idx);

    // state update at commit
    always_comb begin
        n_armed    = r_armed;
        n_active   = r_active;
        n_period   = r_period;
        n_pat_pend = r_pat_pend;
        n_per_pend = r_per_pend;
        n_trip     = r_trip;
        n_action   = r_action;
        n_cmp      = r_cmp;
        n_updated  = r_updated;
        if (i_cmd.commit) begin
            n_updated = 1'b0;
            if (!r_in.start_request) begin
                n_trip  = 1'b1;
                n_armed = 1'b0;
            end else begin
                if (!r_armed) begin
                    n_trip     = 1'b0;
                    n_pat_pend = 1'b1;
                    n_armed    = 1'b1;
                end
                if (sel_valid && (r_active != r_in.pattern_select[llcpwm_pkg::PAT_W-1:0]))
                begin
                    n_active   = r_in.pattern_select[llcpwm_pkg::PAT_W-1:0];
                    n_pat_pend = 1'b1;
                end
                if (np != r_period) begin
                    n_period   = np;
                    n_per_pend = 1'b1;
                end
                if (sel_valid) begin
                    if (n_pat_pend) begin
                        n_action = llcpwm_pkg::rom_mask(rom_idx);
                    end
                    if (n_pat_pend || n_per_pend) begin
                        for (int i = 0; i < llcpwm_pkg::NUM_CMP; i++) begin
                            n_cmp[i] = llcpwm_pkg::calc_compare(codes[i], np,
                                                                i_cfg.dead_count);
                        end
                        n_pat_pend = 1'b0;
                        n_per_pend = 1'b0;
                        n_updated  = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed    <= 1'b0;
            r_active   <= llcpwm_pkg::RST_PATTERN;
            r_period   <= llcpwm_pkg::RST_PERIOD;
            r_pat_pend <= 1'b0;
            r_per_pend <= 1'b0;
            r_trip     <= 1'b1;
            r_action   <= '0;
            r_updated  <= 1'b0;
            for (int i = 0; i < llcpwm_pkg::NUM_CMP; i++) begin
                r_cmp[i] <= '0;
            end
        end else begin
            r_armed    <= n_armed;
            r_active   <= n_active;
            r_period   <= n_period;
            r_pat_pend <= n_pat_pend;
            r_per_pend <= n_per_pend;
            r_trip     <= n_trip;
            r_action   <= n_action;
            r_updated  <= n_updated;
            r_cmp      <= n_cmp;
        end
    end

    // output register, holds while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.trip_forced      <= r_trip;
            r_out.period_out       <= r_period;
            r_out.action_high_mask <= r_action;
            r_out.cmp_1a           <= r_cmp[0];
            r_out.cmp_1b           <= r_cmp[1];
            r_out.cmp_2a           <= r_cmp[2];
            r_out.cmp_2b           <= r_cmp[3];
            r_out.cmp_3a           <= r_cmp[4];
            r_out.cmp_3b           <= r_cmp[5];
            r_out.compares_updated <= r_updated;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // status to the controller
    assign o_sts.start_low = !r_in.start_request;
    assign o_sts.div_last  = (r_cnt == llcpwm_pkg::CNT_W'(llcpwm_pkg::DIV_STEPS - 1));
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

endmodule

FILE: hw/rtl/llc_pwm_pattern_period_updater.sv
// ----------------------------------------------------------------------------
// llc_pwm_pattern_period_updater
// Per-tick PWM period and switching pattern update for an LLC stage.
// ----------------------------------------------------------------------------
// One request per PWM tick. After acceptance, a request with start high passes
// through the multiply state for base_period * 50000, the bit-serial restoring
// divide by freq_hz (one quotient bit per cycle), the commit state that clamps
// the period and evaluates the pattern table, and the output state that loads
// the output register. A request with start low skips the divide. No new
// request is taken until the output state has handed its result on. A request
// is taken while a previous result still waits in the output register; the new
// result is loaded once that one leaves. Configuration registers are written
// through their own port, always ready, and must only be written while no
// request is in flight.
module llc_pwm_pattern_period_updater (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  llcpwm_pkg::t_in                    i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output llcpwm_pkg::t_out                   o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [llcpwm_pkg::CIDX_W-1:0]      i_cfg_index,
    input  logic [llcpwm_pkg::CDATA_W-1:0]     i_cfg_data
);

    llcpwm_pkg::t_cfg r_cfg;
    llcpwm_pkg::t_cmd cmd;
    llcpwm_pkg::t_sts sts;

    // configuration register file, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_period <= llcpwm_pkg::RST_BASE_PERIOD;
            r_cfg.dead_count  <= llcpwm_pkg::RST_DEAD_COUNT;
            r_cfg.min_period  <= llcpwm_pkg::RST_MIN_PERIOD;
            r_cfg.max_period  <= llcpwm_pkg::RST_MAX_PERIOD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                llcpwm_pkg::CFG_BASE_PERIOD: r_cfg.base_period <= i_cfg_data;
                llcpwm_pkg::CFG_DEAD_COUNT:
                    r_cfg.dead_count <= i_cfg_data[llcpwm_pkg::DEAD_W-1:0];
                llcpwm_pkg::CFG_MIN_PERIOD:  r_cfg.min_period  <= i_cfg_data;
                llcpwm_pkg::CFG_MAX_PERIOD:  r_cfg.max_period  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // sequencer
    llcpwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    llcpwm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

FILE: bench/llc_pwm_pattern_period_updater_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// llc_pwm_pattern_period_updater_checker
// Watches the request, result and register channels of the period updater,
// keeps its own copy of arm state, period, pattern and compare registers,
// predicts the result of every accepted request and compares each accepted
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module llc_pwm_pattern_period_updater_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  llcpwm_pkg::t_in                    i_in_data,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  llcpwm_pkg::t_out                   i_out_data,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [llcpwm_pkg::CIDX_W-1:0]      i_cfg_index,
    input  logic [llcpwm_pkg::CDATA_W-1:0]     i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_outstanding
);
    import llcpwm_pkg::*;

    // register copies
    logic [PER_W-1:0]  base_period_q;
    logic [DEAD_W-1:0] dead_count_q;
    logic [PER_W-1:0]  min_period_q;
    logic [PER_W-1:0]  max_period_q;

    // block state copy
    logic              armed_q;
    logic [PAT_W-1:0]  active_pat_q;
    logic [PER_W-1:0]  period_q;
    logic              pat_pending_q;
    logic              per_pending_q;
    logic              trip_q;
    logic [MASK_W-1:0] action_q;
    logic [PER_W-1:0]  cmp_q [NUM_CMP];

    t_out expected_ticks [$];
    t_out oldest;
    int   fail_count = 0;
    int   waiting    = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = waiting;

    // polarity mask of a pattern, index is pattern number minus one
    function automatic logic [MASK_W-1:0] polarity_of(input logic [2:0] idx);
        logic [MASK_W-1:0] m;
        case (idx)
            3'd0:    m = 6'h19;
            3'd1:    m = 6'h26;
            3'd2:    m = 6'h19;
            3'd3:    m = 6'h29;
            3'd4:    m = 6'h25;
            3'd5:    m = 6'h2D;
            3'd6:    m = 6'h1E;
            default: m = 6'h2D;
        endcase
        return m;
    endfunction

    // compare codes of a pattern, output 1A in the top two bits
    function automatic logic [2*NUM_CMP-1:0] codes_of(input logic [2:0] idx);
        logic [2*NUM_CMP-1:0] c;
        case (idx)
            3'd0:    c = {CMP_HMINUS, CMP_PER, CMP_HPLUS, CMP_PER, CMP_HMINUS, CMP_PER};
            3'd1:    c = {CMP_PER, CMP_HMINUS, CMP_PER, CMP_HPLUS, CMP_PER, CMP_HMINUS};
            3'd2:    c = {CMP_HMINUS, CMP_HPLUS, CMP_HPLUS, CMP_HMINUS, CMP_HMINUS, CMP_HPLUS};
            3'd3:    c = {CMP_HMINUS, CMP_HPLUS, CMP_HPLUS, CMP_HMINUS, CMP_HPLUS, CMP_HMINUS};
            3'd4:    c = {CMP_HMINUS, CMP_HPLUS, CMP_HMINUS, CMP_HPLUS, CMP_HPLUS, CMP_HMINUS};
            3'd5:    c = {CMP_PER, CMP_HPLUS, CMP_PER, CMP_PER, CMP_PER, CMP_HMINUS};
            3'd6:    c = {CMP_HPLUS, CMP_PER, CMP_PER, CMP_PER, CMP_HMINUS, CMP_PER};
            default: c = {CMP_HMINUS, CMP_HPLUS, CMP_PER, CMP_PER, CMP_HPLUS, CMP_HMINUS};
        endcase
        return c;
    endfunction

    // exact base * nominal / freq, saturated, then min clamp before max clamp
    function automatic logic [PER_W-1:0] period_for(input logic [FREQ_W-1:0] freq);
        longint unsigned  quot;
        logic [PER_W-1:0] p;
        if (freq == '0) begin
            p = SAT_PERIOD;
        end else begin
            quot = (longint'(base_period_q) * longint'(NOMINAL_HZ)) / longint'(freq);
            p = (quot > longint'(SAT_PERIOD)) ? SAT_PERIOD : quot[PER_W-1:0];
        end
        if (p < min_period_q) begin
            p = min_period_q;
        end else if (p > max_period_q) begin
            p = max_period_q;
        end
        return p;
    endfunction

    // full period or half period shifted by the dead band, kept within 0..period
    function automatic logic [PER_W-1:0] compare_for(
        input logic [1:0]       code,
        input logic [PER_W-1:0] period
    );
        logic [PER_W:0] half;
        logic [PER_W:0] v;
        half = {2'b00, period[PER_W-1:1]};
        if (code == CMP_PER) begin
            v = {1'b0, period};
        end else if (code == CMP_HMINUS) begin
            v = (dead_count_q > half) ? '0 : half - dead_count_q;
        end else begin
            v = half + dead_count_q;
        end
        if (v > {1'b0, period}) begin
            v = {1'b0, period};
        end
        return v[PER_W-1:0];
    endfunction

    // one period tick: update the state copy and form the expected result
    function automatic t_out advance_tick(input t_in req);
        logic                 sel_ok;
        logic [PER_W-1:0]     np;
        logic [2:0]           idx;
        logic [2*NUM_CMP-1:0] codes;
        logic                 upd;
        t_out                 r;
        upd = 1'b0;
        if (!req.start_request) begin
            trip_q  = 1'b1;
            armed_q = 1'b0;
        end else begin
            sel_ok = (req.pattern_select >= 1) && (req.pattern_select <= PATTERNS);
            idx    = req.pattern_select[2:0] - 3'd1;
            if (!armed_q) begin
                trip_q        = 1'b0;
                pat_pending_q = 1'b1;
                armed_q       = 1'b1;
            end
            if (sel_ok && ({4'd0, active_pat_q} != req.pattern_select)) begin
                active_pat_q  = req.pattern_select[PAT_W-1:0];
                pat_pending_q = 1'b1;
            end
            np = period_for(req.freq_hz);
            if (np != period_q) begin
                period_q      = np;
                per_pending_q = 1'b1;
            end
            if (sel_ok) begin
                codes = codes_of(idx);
                if (pat_pending_q) begin
                    action_q = polarity_of(idx);
                end
                if (pat_pending_q || per_pending_q) begin
                    for (int k = 0; k < NUM_CMP; k++) begin
                        cmp_q[k] = compare_for(codes[2*(NUM_CMP-1-k) +: 2], np);
                    end
                    pat_pending_q = 1'b0;
                    per_pending_q = 1'b0;
                    upd           = 1'b1;
                end
            end
        end
        r.trip_forced      = trip_q;
        r.period_out       = period_q;
        r.action_high_mask = action_q;
        r.cmp_1a           = cmp_q[0];
        r.cmp_1b           = cmp_q[1];
        r.cmp_2a           = cmp_q[2];
        r.cmp_2b           = cmp_q[3];
        r.cmp_3a           = cmp_q[4];
        r.cmp_3b           = cmp_q[5];
        r.compares_updated = upd;
        return r;
    endfunction

    task automatic check_field(
        input string       label,
        input logic [31:0] want,
        input logic [31:0] got
    );
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            fail_count++;
        end
    endtask

    // track registers, predict on each request, compare on each result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            base_period_q = RST_BASE_PERIOD;
            dead_count_q  = RST_DEAD_COUNT;
            min_period_q  = RST_MIN_PERIOD;
            max_period_q  = RST_MAX_PERIOD;
            armed_q       = 1'b0;
            active_pat_q  = RST_PATTERN;
            period_q      = RST_PERIOD;
            pat_pending_q = 1'b0;
            per_pending_q = 1'b0;
            trip_q        = 1'b1;
            action_q      = '0;
            for (int k = 0; k < NUM_CMP; k++) begin
                cmp_q[k] = '0;
            end
            expected_ticks.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BASE_PERIOD: base_period_q = i_cfg_data;
                    CFG_DEAD_COUNT:  dead_count_q  = i_cfg_data[DEAD_W-1:0];
                    CFG_MIN_PERIOD:  min_period_q  = i_cfg_data;
                    CFG_MAX_PERIOD:  max_period_q  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_ticks.size() == 0) begin
                    $display("%0t: result with no request pending, expected none, actual %h",
                             $time, i_out_data);
                    fail_count++;
                end else begin
                    oldest = expected_ticks.pop_front();
                    check_field("trip_forced", 32'(oldest.trip_forced),
                                32'(i_out_data.trip_forced));
                    check_field("period_out", 32'(oldest.period_out),
                                32'(i_out_data.period_out));
                    check_field("action_high_mask", 32'(oldest.action_high_mask),
                                32'(i_out_data.action_high_mask));
                    check_field("cmp_1a", 32'(oldest.cmp_1a), 32'(i_out_data.cmp_1a));
                    check_field("cmp_1b", 32'(oldest.cmp_1b), 32'(i_out_data.cmp_1b));
                    check_field("cmp_2a", 32'(oldest.cmp_2a), 32'(i_out_data.cmp_2a));
                    check_field("cmp_2b", 32'(oldest.cmp_2b), 32'(i_out_data.cmp_2b));
                    check_field("cmp_3a", 32'(oldest.cmp_3a), 32'(i_out_data.cmp_3a));
                    check_field("cmp_3b", 32'(oldest.cmp_3b), 32'(i_out_data.cmp_3b));
                    check_field("compares_updated", 32'(oldest.compares_updated),
                                32'(i_out_data.compares_updated));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_ticks.push_back(advance_tick(i_in_data));
            end
        end
        waiting = expected_ticks.size();
    end

endmodule

FILE: bench/tb_llc_pwm_pattern_period_updater.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_llc_pwm_pattern_period_updater
// Drives period tick requests and register writes into the period updater:
// a directed pass over clamps, saturation, trip and pattern cases, then
// random requests under several register settings and idling mixes. The
// checker beside the block does the prediction; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_llc_pwm_pattern_period_updater;
    import llcpwm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    t_in                 in_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_out                out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index = '0;
    logic [CDATA_W-1:0]  cfg_data  = '0;

    int fail_count;
    int outstanding;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int out_stall_pct = 0;

    // register values as last written, used to aim frequencies into the clamp window
    int unsigned cur_base = 32'(RST_BASE_PERIOD);
    int unsigned cur_min  = 32'(RST_MIN_PERIOD);
    int unsigned cur_max  = 32'(RST_MAX_PERIOD);

    logic [SEL_W-1:0]  prev_sel  = 8'd1;
    logic [FREQ_W-1:0] prev_freq = 20'd50000;

    llc_pwm_pattern_period_updater u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    llc_pwm_pattern_period_updater_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #1 clk = ~clk;

    // receiver back-pressure
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // run watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // one tick request, with idle cycles ahead of it at the sender's idle rate
    task automatic send_tick(
        input logic              start,
        input logic [SEL_W-1:0]  sel,
        input logic [FREQ_W-1:0] freq
    );
        t_in req;
        req.start_request  = start;
        req.pattern_select = sel;
        req.freq_hz        = freq;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
        prev_sel  = sel;
        prev_freq = freq;
    endtask

    // stop requesting and wait until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // all four registers, only while nothing is in flight
    task automatic write_settings(
        input logic [CDATA_W-1:0] base,
        input logic [CDATA_W-1:0] dead,
        input logic [CDATA_W-1:0] minp,
        input logic [CDATA_W-1:0] maxp
    );
        drain();
        write_reg(CFG_BASE_PERIOD, base);
        write_reg(CFG_DEAD_COUNT, dead);
        write_reg(CFG_MIN_PERIOD, minp);
        write_reg(CFG_MAX_PERIOD, maxp);
        cfg_valid <= 1'b0;
        cur_base = 32'(base);
        cur_min  = 32'(minp);
        cur_max  = 32'(maxp);
    endtask

    // frequency aimed at a period inside the clamp window, with some outliers
    function automatic logic [FREQ_W-1:0] pick_freq();
        int unsigned     roll;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     target;
        longint unsigned f;
        roll = $urandom_range(99);
        if (roll < 5) return '0;
        if (roll < 18) return FREQ_W'($urandom);
        if (roll < 26) return FREQ_W'($urandom_range(1, 3000));
        lo     = (cur_min < cur_max) ? cur_min : cur_max;
        hi     = (cur_min < cur_max) ? cur_max : cur_min;
        target = $urandom_range(lo, hi);
        if (target == 0) target = 1;
        f = (longint'(cur_base) * longint'(NOMINAL_HZ)) / target;
        if (f > 64'hFFFFF) f = 64'hFFFFF;
        if (f == 0) f = 64'($urandom_range(1, 1048575));
        return f[FREQ_W-1:0];
    endfunction

    // mostly armed requests with valid patterns, some trips, repeats and bad patterns
    task automatic run_random(input int count);
        int unsigned roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                send_tick(1'b0, SEL_W'($urandom_range(0, 255)), FREQ_W'($urandom));
            end else if (roll < 18) begin
                send_tick(1'b1,
                          ($urandom_range(1) != 0) ? SEL_W'($urandom_range(9, 255)) : 8'd0,
                          pick_freq());
            end else if (roll < 30) begin
                send_tick(1'b1, prev_sel, prev_freq);
            end else if (roll < 40) begin
                send_tick(1'b1, SEL_W'($urandom_range(1, PATTERNS)), prev_freq);
            end else begin
                send_tick(1'b1, SEL_W'($urandom_range(1, PATTERNS)), pick_freq());
            end
        end
    endtask

    initial begin
        int unsigned rnd_min;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 18;
        out_stall_pct = 76;

        // directed pass at reset register values
        send_tick(1'b0, 8'd0, 20'd0);
        send_tick(1'b1, 8'd1, 20'd50000);
        send_tick(1'b1, 8'd1, 20'd50000);
        send_tick(1'b1, 8'd2, 20'd50000);
        send_tick(1'b1, 8'd2, 20'd0);
        send_tick(1'b1, 8'd3, 20'hFFFFF);
        send_tick(1'b1, 8'd4, 20'd763);
        send_tick(1'b1, 8'd5, 20'd762);
        send_tick(1'b1, 8'd6, 20'd40000);
        send_tick(1'b1, 8'd7, 20'd60000);
        send_tick(1'b1, 8'd8, 20'd100000);
        send_tick(1'b1, 8'd0, 20'd30000);
        send_tick(1'b1, 8'd9, 20'd30000);
        send_tick(1'b1, 8'd255, 20'hFFFFF);
        send_tick(1'b1, 8'd8, 20'hFFFFF);
        send_tick(1'b0, 8'd3, 20'd25000);
        send_tick(1'b0, 8'd255, 20'hFFFFF);
        send_tick(1'b1, 8'd8, 20'hFFFFF);
        send_tick(1'b1, 8'd1, 20'd50001);
        send_tick(1'b1, 8'd1, 20'd49999);
        send_tick(1'b1, 8'd128, 20'h80000);
        send_tick(1'b1, 8'd4, 20'd50000);

        // widest window, largest base and dead band
        write_settings(16'd65535, 16'd4095, 16'd1, 16'd65535);
        run_random(75);
        // smallest base and no dead band
        write_settings(16'd1, 16'd0, 16'd1, 16'd65535);
        run_random(75);

        send_idle_pct = 76;
        out_stall_pct = 18;

        // min above max, min test wins
        write_settings(16'd2000, 16'd700, 16'd3000, 16'd100);
        run_random(75);
        write_settings(16'd1000, 16'd50, 16'd500, 16'd2000);
        run_random(75);

        send_idle_pct = 0;
        out_stall_pct = 0;

        rnd_min = $urandom_range(1, 2000);
        write_settings(CDATA_W'($urandom_range(1, 65535)), CDATA_W'($urandom_range(0, 4095)),
                       CDATA_W'(rnd_min), CDATA_W'($urandom_range(rnd_min, 65535)));
        run_random(75);

        // zero base, dead band written with upper bits set
        write_settings(16'd0, 16'hFFFF, 16'd300, 16'd65535);
        run_random(25);

        // unused register index must be ignored
        drain();
        write_reg(8'hFF, 16'hFFFF);
        cfg_valid <= 1'b0;
        write_settings(16'd1500, 16'd120, 16'd600, 16'd3000);
        run_random(50);

        drain();
        repeat (40) @(posedge clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
